FILE: rtl/nsc_pkg.sv
`default_nettype none

package nsc_pkg;

  // Line store capacity; a byte arriving at a full store starts a new line
  localparam int unsigned LINE_MAX = 128;
  localparam int unsigned HDR_LEN  = 6;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Header strings, first character at index 0
  localparam logic [0:HDR_LEN-1][7:0] HDR_GGA = "$GPGGA";
  localparam logic [0:HDR_LEN-1][7:0] HDR_RMC = "$GPRMC";
  localparam logic [0:HDR_LEN-1][7:0] HDR_GSA = "$GPGSA";

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_RMC   = 2'd2,
    KIND_GSA   = 2'd3
  } kind_t;

  // Per-line state: delay line (index 0 newest), XOR, count, header
  typedef struct packed {
    logic [2:0][7:0]           tail;
    logic [7:0]                sum;
    logic [7:0]                count;
    logic [0:HDR_LEN-1][7:0]   hdr;
  } line_t;

  // One result request
  typedef struct packed {
    kind_t      kind;
    logic       ok;
    logic [7:0] sum;
    logic [7:0] length;
  } res_t;

  // Append one content byte to the line
  function automatic line_t push_byte(line_t s, logic [7:0] b);
    line_t r;
    r = s;
    if (r.count >= 8'(LINE_MAX)) begin
      r = '0;
    end
    if (r.count < 8'(HDR_LEN)) begin
      r.hdr[r.count[2:0]] = b;
    end
    // byte leaving the delay line has index count-3; XOR it from index 1 on
    if (r.count >= 8'd4) begin
      r.sum = r.sum ^ r.tail[2];
    end
    r.tail  = {r.tail[1], r.tail[0], b};
    r.count = r.count + 8'd1;
    return r;
  endfunction

  // Uppercase ASCII hex digit
  function automatic logic [7:0] hex_digit(logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h41 + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

  function automatic kind_t classify(logic [0:HDR_LEN-1][7:0] h);
    kind_t k;
    if (h == HDR_GGA) begin
      k = KIND_GGA;
    end else if (h == HDR_RMC) begin
      k = KIND_RMC;
    end else if (h == HDR_GSA) begin
      k = KIND_GSA;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nsc_line_core.sv
`default_nettype none

module nsc_line_core
  import nsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic [7:0] byte_in,
  output logic            res_valid,
  output res_t            res
);

  line_t line;
  line_t line_next;
  line_t mid;
  logic  saw_cr;
  logic  saw_cr_next;

  // Line end detect, CR replay and byte append
  always_comb begin
    mid         = line;
    line_next   = line;
    saw_cr_next = saw_cr;
    res_valid   = 1'b0;
    res.kind    = classify(line.hdr);
    res.sum     = line.sum;
    res.length  = line.count;
    res.ok      = (line.count >= 8'd4) &&
                  (line.tail[1] == hex_digit(line.sum[7:4])) &&
                  (line.tail[0] == hex_digit(line.sum[3:0]));
    if (saw_cr && byte_in == CHAR_LF) begin
      res_valid   = 1'b1;
      line_next   = '0;
      saw_cr_next = 1'b0;
    end else begin
      // a pending CR without LF is content
      if (saw_cr) begin
        mid = push_byte(line, CHAR_CR);
      end
      if (byte_in == CHAR_CR) begin
        line_next   = mid;
        saw_cr_next = 1'b1;
      end else begin
        line_next   = push_byte(mid, byte_in);
        saw_cr_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line   <= '0;
      saw_cr <= 1'b0;
    end else if (go) begin
      line   <= line_next;
      saw_cr <= saw_cr_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nmea_sentence_checker.sv
`default_nettype none

// NMEA line checker: takes one received byte per request on the input channel
// and gives one result request for each line closed by CR LF (kind, checksum
// match, computed XOR, content length). A byte is accepted every cycle while
// the output side keeps up. A result follows its LF through the input register
// and the result register: the LF waits in the input register, and the
// line-state update (which may append a held CR and the new byte together)
// loads the result register once the result slot is free or draining. The
// result register frees as it is taken, so output stalls hold the input side
// only once both registers are full.
module nmea_sentence_checker
  import nsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      sentence_kind,
  output logic            checksum_ok,
  output logic [7:0]      computed_sum,
  output logic [7:0]      line_length
);

  logic       s1_valid;
  logic       s1_valid_next;
  logic [7:0] s1_byte;
  logic       s1_go;
  logic       res_valid;
  res_t       res;
  res_t       out_res;
  logic       out_valid_next;

  // Input stage advances when the result slot is free or draining
  assign s1_go         = s1_valid && (!out_valid || out_ready);
  assign in_ready      = !s1_valid || s1_go;
  assign s1_valid_next = (s1_valid && !s1_go) || (in_valid && in_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  nsc_line_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (s1_go),
    .byte_in   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_comb begin
    if (s1_go && res_valid) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_res <= res;
    end
  end

  assign sentence_kind = out_res.kind;
  assign checksum_ok   = out_res.ok;
  assign computed_sum  = out_res.sum;
  assign line_length   = out_res.length;

endmodule

`default_nettype wire

FILE: rtl/nsc_checker.sv
`default_nettype none

module nsc_checker
  import nsc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] sentence_kind,
  input wire logic       checksum_ok,
  input wire logic [7:0] computed_sum,
  input wire logic [7:0] line_length
);

  // A stalled result request holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sentence_kind) &&
      $stable(checksum_ok) && $stable(computed_sum) && $stable(line_length))
    else $error("result changed while stalled");

  // Short lines never pass and have nothing in the XOR
  assert property (@(posedge clk) disable iff (rst)
    out_valid && line_length < 8'd4 |-> !checksum_ok && computed_sum == 8'd0)
    else $error("short line reported a checksum");

  // A known header needs six content bytes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sentence_kind != KIND_OTHER |-> line_length >= 8'(HDR_LEN))
    else $error("header matched on a short line");

  // Length never exceeds the line store
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_length <= 8'(LINE_MAX))
    else $error("line length beyond store");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .sentence_kind (sentence_kind),
  .checksum_ok   (checksum_ok),
  .computed_sum  (computed_sum),
  .line_length   (line_length)
);

`default_nettype wire

FILE: tb/nmea_sentence_checker_tb.sv
`default_nettype none

module nmea_sentence_checker_tb;
  import nsc_pkg::*;

  // One expected line result
  typedef struct {
    kind_t      kind;
    logic       ok;
    logic [7:0] sum;
    logic [7:0] len;
  } line_result_t;

  localparam int STIM_BYTES   = 850;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 30;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] sentence_kind;
  logic       checksum_ok;
  logic [7:0] computed_sum;
  logic [7:0] line_length;

  nmea_sentence_checker uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sentence_kind (sentence_kind),
    .checksum_ok   (checksum_ok),
    .computed_sum  (computed_sum),
    .line_length   (line_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes waiting to be sent, and line results waiting to come out
  logic [7:0]   byte_q[$];
  line_result_t pending_lines[$];

  // Line tracker state
  logic [2:0][7:0]         tail_q;
  logic [7:0]              xor_acc;
  logic [7:0]              content_cnt;
  logic [0:HDR_LEN-1][7:0] hdr_seen;
  logic                    cr_held;

  int   n_sent      = 0;
  int   n_results   = 0;
  int   n_sum_match = 0;
  int   n_kind[4]   = '{0, 0, 0, 0};
  int   err_cnt     = 0;
  int   quiet_cycles = 0;
  logic idle_window = 1'b0;

  // Uppercase ASCII hex of one nibble
  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 | {4'd0, n}) : (8'd55 + {4'd0, n});
  endfunction

  function automatic kind_t header_kind(input logic [0:HDR_LEN-1][7:0] h);
    kind_t k;
    case (h)
      HDR_GGA: k = KIND_GGA;
      HDR_RMC: k = KIND_RMC;
      HDR_GSA: k = KIND_GSA;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

  task automatic clear_line_state();
    tail_q      = '0;
    xor_acc     = 8'd0;
    content_cnt = 8'd0;
    hdr_seen    = '0;
  endtask

  // Add one content byte; a full store restarts the line first
  task automatic append_content(input logic [7:0] b);
    if (content_cnt >= LINE_MAX) begin
      clear_line_state();
    end
    if (content_cnt < HDR_LEN) begin
      hdr_seen[content_cnt[2:0]] = b;
    end
    // byte leaving the delay line is in the XOR from index 1 on
    if (content_cnt >= 8'd4) begin
      xor_acc = xor_acc ^ tail_q[2];
    end
    tail_q      = {tail_q[1], tail_q[0], b};
    content_cnt = content_cnt + 8'd1;
  endtask

  // Follow one accepted byte; CR LF closes the line and queues its result
  task automatic track_rx_byte(input logic [7:0] b);
    line_result_t r;
    if (cr_held && b == CHAR_LF) begin
      r.kind = header_kind(hdr_seen);
      r.ok   = (content_cnt >= 8'd4) && (tail_q[1] == hex_ascii(xor_acc[7:4])) &&
               (tail_q[0] == hex_ascii(xor_acc[3:0]));
      r.sum  = xor_acc;
      r.len  = content_cnt;
      pending_lines.push_back(r);
      clear_line_state();
      cr_held = 1'b0;
    end else begin
      // a held CR without LF is content
      if (cr_held) begin
        append_content(CHAR_CR);
        cr_held = 1'b0;
      end
      if (b == CHAR_CR) begin
        cr_held = 1'b1;
      end else begin
        append_content(b);
      end
    end
  endtask

  // Stimulus builders
  task automatic put_byte(input logic [7:0] b);
    byte_q.push_back(b);
  endtask

  task automatic put_line_end();
    byte_q.push_back(CHAR_CR);
    byte_q.push_back(CHAR_LF);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    if ($urandom_range(0, 24) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_CR) begin
        b = ",";
      end
    end else begin
      b = 8'($urandom_range(32, 126));
    end
    return b;
  endfunction

  // Sentence with header select (0 GGA, 1 RMC, 2 GSA, 3 near miss, 4 stub),
  // body length and flaw (0 none, 1 bad sum, 2 lowercase hex, 3 no star)
  task automatic put_sentence(input int hdr_sel, input int body_len, input int flaw);
    logic [7:0]              line_bytes[$];
    logic [0:HDR_LEN-1][7:0] h;
    logic [7:0]              sum;
    logic [7:0]              hi;
    logic [7:0]              lo;
    case (hdr_sel)
      0: h = HDR_GGA;
      1: h = HDR_RMC;
      2: h = HDR_GSA;
      default: begin
        h = ($urandom_range(0, 1) == 0) ? HDR_GGA : HDR_GSA;
        h[$urandom_range(0, 5)] = 8'($urandom_range(65, 90));
      end
    endcase
    if (hdr_sel == 4) begin
      // header cut short by the star
      line_bytes.push_back("$");
      line_bytes.push_back(8'($urandom_range(65, 90)));
    end else begin
      for (int i = 0; i < HDR_LEN; i++) begin
        line_bytes.push_back(h[i]);
      end
      for (int i = 0; i < body_len; i++) begin
        line_bytes.push_back(body_byte());
      end
    end
    sum = 8'd0;
    for (int i = 1; i < line_bytes.size(); i++) begin
      sum = sum ^ line_bytes[i];
    end
    hi = hex_ascii(sum[7:4]);
    lo = hex_ascii(sum[3:0]);
    if (flaw == 1) begin
      lo = hex_ascii(sum[3:0] ^ 4'($urandom_range(1, 15)));
    end else if (flaw == 2) begin
      if (hi >= "A") hi = hi | 8'h20;
      if (lo >= "A") lo = lo | 8'h20;
    end
    line_bytes.push_back((flaw == 3) ? "#" : "*");
    line_bytes.push_back(hi);
    line_bytes.push_back(lo);
    foreach (line_bytes[i]) begin
      byte_q.push_back(line_bytes[i]);
    end
    put_line_end();
  endtask

  // Driver: presents queued bytes, tracks accepted ones
  always @(posedge clk) begin : byte_driver
    int in_gap;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
      clear_line_state();
      cr_held = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_rx_byte(rx_byte);
        n_sent++;
      end
      // bursty stretches alternate with clean ones; none near the end
      idle_window <= (byte_q.size() > 100) && (((byte_q.size() / 150) % 2) == 0);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          rx_byte  <= byte_q.pop_front();
          in_valid <= 1'b1;
          if (idle_window && $urandom_range(0, 15) == 0) begin
            in_gap = $urandom_range(1, 11);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result request with the oldest expected line
  always @(posedge clk) begin : result_check
    int           out_gap;
    line_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        n_kind[sentence_kind]++;
        if (checksum_ok) n_sum_match++;
        if (pending_lines.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result with no line pending: kind %0d ok %0d sum %0h len %0d",
                     $time, sentence_kind, checksum_ok, computed_sum, line_length);
        end else begin
          want = pending_lines.pop_front();
          if (sentence_kind !== want.kind) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: sentence_kind expected %0d got %0d",
                       $time, want.kind, sentence_kind);
          end
          if (checksum_ok !== want.ok) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: checksum_ok expected %0d got %0d",
                       $time, want.ok, checksum_ok);
          end
          if (computed_sum !== want.sum) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: computed_sum expected %02h got %02h",
                       $time, want.sum, computed_sum);
          end
          if (line_length !== want.len) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: line_length expected %0d got %0d",
                       $time, want.len, line_length);
          end
        end
      end
      // output stalls in bursts
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_window && $urandom_range(0, 19) == 0) begin
          out_gap = $urandom_range(1, 11);
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int total;
    int pick;
    int hdr_sel;
    int flaw;
    int n;

    // directed: empty line, short lines with extreme bytes, lone LF,
    // lone CR and CR CR LF, minimal GGA, full store and store overflow
    put_line_end();
    put_byte(8'h00);
    put_line_end();
    put_byte(8'hFF);
    put_byte("A");
    put_byte(CHAR_LF);
    put_line_end();
    put_byte("Q");
    put_byte(CHAR_CR);
    put_byte("W");
    put_byte(CHAR_CR);
    put_line_end();
    put_sentence(0, 0, 0);
    put_sentence(1, LINE_MAX - 9, 0);
    put_sentence(2, LINE_MAX - 3, 0);

    // random: mostly well-formed sentences, some noise and broken lines
    while (byte_q.size() < STIM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        n = $urandom_range(0, 9);
        hdr_sel = (n < 2) ? 0 : (n < 4) ? 1 : (n < 6) ? 2 : (n < 8) ? 3 : (n == 8) ? 0 : 4;
        n = $urandom_range(0, 9);
        flaw = (n < 7) ? 0 : n - 6;
        put_sentence(hdr_sel, $urandom_range(0, 40), flaw);
      end else if (pick < 82) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          put_byte(8'($urandom_range(0, 255)));
        end
      end else if (pick < 90) begin
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          put_byte(body_byte());
        end
        put_line_end();
      end else if (pick < 98) begin
        n = $urandom_range(0, 3);
        if (n == 0) begin
          put_byte(CHAR_CR);
          put_byte(body_byte());
        end else if (n == 1) begin
          put_byte(CHAR_CR);
          put_byte(CHAR_CR);
        end else if (n == 2) begin
          put_byte(CHAR_LF);
        end else begin
          put_byte(CHAR_CR);
          put_line_end();
        end
      end else if (pick < 99) begin
        put_sentence($urandom_range(0, 2), $urandom_range(LINE_MAX - 12, LINE_MAX + 8), 0);
      end else begin
        put_sentence($urandom_range(0, 2), $urandom_range(0, 20), 0);
      end
    end
    total = byte_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_sent < total) @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, checked %0d lines: %0d other, %0d GGA, %0d RMC, %0d GSA",
             n_sent, n_results, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
    $display("Checksum matched on %0d lines, %0d field errors", n_sum_match, err_cnt);
    if (err_cnt == 0 && pending_lines.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/nsc_pkg.sv
rtl/nsc_line_core.sv
rtl/nmea_sentence_checker.sv
rtl/nsc_checker.sv
tb/nmea_sentence_checker_tb.sv
